@@ sv/mrfifo_pkg.sv @@
// mrfifo_pkg: operation and status codes for the message ring FIFO.
// No dependencies; imported by message_ring_fifo_with_loss_count.
`timescale 1ns / 1ps

package mrfifo_pkg;

    typedef enum logic [1:0] {
        MODE_SEND  = 2'd0,
        MODE_RECV  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_QUERY = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    localparam int unsigned QDEPTH_W  = 5;
    localparam int unsigned QDEPTH_RST = 16;
    localparam int unsigned XDATA_W   = 32;
    localparam int unsigned LOSTOUT_W = 15;
    localparam int unsigned PEND_W    = 5;
    localparam int unsigned APB_W     = 32;
    localparam int unsigned PADDR_W   = 3;
    localparam logic        REG_QDEPTH = 1'b0;

endpackage

@@ sv/message_ring_fifo_with_loss_count.sv @@
// message_ring_fifo_with_loss_count: bounded message FIFO with lost-message counter.
// Depends on mrfifo_pkg and mrfifo_ram.
`timescale 1ns / 1ps

// One transaction per clock while the output side does not stall: each operation
// (send, receive, clear, count query) is decoded and applied to the indices and
// counters in the cycle it is accepted, and its result appears on the output in
// the next cycle, when the ring RAM's registered read data is ready. The ring RAM
// has a single port pair (one write, one read). Input stall is raised only while a
// result is held and the output side stalls. queue_depth is written over the APB
// port at byte address 0; the user must write it only while the block is idle, as
// the block itself does not enforce this. Values above DEPTH act as DEPTH, and zero rejects every send as lost.

module message_ring_fifo_with_loss_count #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int LOST_MAX   = 32767
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  mrfifo_pkg::t_mode                       i_mode,
    input  logic [mrfifo_pkg::XDATA_W-1:0]          i_send_data,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output mrfifo_pkg::t_status                     o_status,
    output logic [mrfifo_pkg::XDATA_W-1:0]          o_recv_data,
    output logic [mrfifo_pkg::LOSTOUT_W-1:0]        o_lost_count,
    output logic [mrfifo_pkg::PEND_W-1:0]           o_pending_count,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [mrfifo_pkg::PADDR_W-1:0]          paddr,
    input  logic [mrfifo_pkg::APB_W-1:0]            pwdata,
    output logic [mrfifo_pkg::APB_W-1:0]            prdata,
    output logic                                    pready
);

    import mrfifo_pkg::*;

    localparam int IW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW  = $clog2(DEPTH + 1);
    localparam int CW  = (FW > QDEPTH_W) ? FW : QDEPTH_W;
    localparam int LW  = $clog2(LOST_MAX + 1);
    localparam logic [IW-1:0] IDX_LAST = IW'(DEPTH - 1);

    logic [QDEPTH_W-1:0] r_qdepth;
    logic [IW-1:0]       r_ridx, n_ridx;
    logic [IW-1:0]       r_widx, n_widx;
    logic [FW-1:0]       r_fill, n_fill;
    logic [LW-1:0]       r_lost, n_lost;

    logic                r_out_valid;
    t_status             r_status, n_status;
    logic [LW-1:0]       r_lost_out, n_lost_out;
    logic [FW-1:0]       r_pend, n_pend;
    logic                r_pop;

    logic                w_acc;
    logic                w_cfg_wr;
    logic [CW-1:0]       w_eff;
    logic [CW-1:0]       w_fill_x;
    logic                w_we, w_re;
    logic [DATA_WIDTH-1:0] w_rdata;

    function automatic logic [IW-1:0] f_adv(input logic [IW-1:0] idx,
                                            input logic [CW-1:0] eff);
        logic [CW-1:0] nx;
        nx = CW'(idx) + CW'(1);
        return (nx >= eff) ? '0 : IW'(nx);
    endfunction

    assign o_stall  = r_out_valid & i_stall;
    assign w_acc    = i_valid & ~o_stall;
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;
    assign prdata   = (paddr[2] == REG_QDEPTH) ? APB_W'(r_qdepth) : '0;

    assign w_eff    = (CW'(r_qdepth) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(r_qdepth);
    assign w_fill_x = CW'(r_fill);

    always_comb begin
        n_ridx     = r_ridx;
        n_widx     = r_widx;
        n_fill     = r_fill;
        n_lost     = r_lost;
        n_status   = ST_OK;
        n_lost_out = '0;
        n_pend     = r_fill;
        w_we       = 1'b0;
        w_re       = 1'b0;
        unique case (i_mode)
            MODE_SEND: begin
                if (w_fill_x >= w_eff) begin
                    n_status = ST_FULL;
                    if (r_lost < LW'(LOST_MAX)) begin
                        n_lost = r_lost + LW'(1);
                    end
                end else begin
                    w_we   = w_acc;
                    n_fill = r_fill + FW'(1);
                    n_widx = f_adv(r_widx, w_eff);
                end
                n_pend = n_fill;
            end
            MODE_RECV: begin
                if (r_fill == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_re       = w_acc;
                    n_fill     = r_fill - FW'(1);
                    n_ridx     = f_adv(r_ridx, w_eff);
                    n_lost_out = r_lost;
                    n_lost     = '0;
                end
                n_pend = n_fill;
            end
            MODE_CLEAR: begin
                if (r_fill != '0) begin
                    n_lost = '0;
                    n_fill = '0;
                    n_ridx = IDX_LAST;
                    n_widx = IDX_LAST;
                end
            end
            MODE_QUERY: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qdepth    <= QDEPTH_W'(QDEPTH_RST);
            r_ridx      <= IDX_LAST;
            r_widx      <= IDX_LAST;
            r_fill      <= '0;
            r_lost      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_wr && paddr[2] == REG_QDEPTH) begin
                r_qdepth <= pwdata[QDEPTH_W-1:0];
            end
            if (w_acc) begin
                r_ridx <= n_ridx;
                r_widx <= n_widx;
                r_fill <= n_fill;
                r_lost <= n_lost;
            end
            if (w_acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_status   <= n_status;
            r_lost_out <= n_lost_out;
            r_pend     <= n_pend;
            r_pop      <= w_re;
        end
    end

    mrfifo_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH),
        .AW    (IW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (n_widx & IDX_LAST),
        .i_wdata (DATA_WIDTH'(i_send_data)),
        .i_re    (w_re),
        .i_raddr (n_ridx),
        .o_rdata (w_rdata)
    );

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_recv_data     = r_pop ? XDATA_W'(w_rdata) : '0;
    assign o_lost_count    = LOSTOUT_W'(r_lost_out);
    assign o_pending_count = PEND_W'(r_pend);

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_fill) <= CW'(DEPTH))
        else $error("fill count above ring depth");

    a_lost_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lost <= LW'(LOST_MAX))
        else $error("lost counter above saturation limit");

    a_reject_keeps_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_mode == MODE_SEND && w_fill_x >= w_eff) |=> $stable(r_fill))
        else $error("rejected send changed fill count");

    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_mode == MODE_RECV && r_fill != '0)
            |=> (r_fill == $past(r_fill) - FW'(1)) && (r_lost == '0))
        else $error("receive did not pop or clear lost counter");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_recv_data == '0 && o_lost_count == '0))
        else $error("failed operation reported data or lost count");

endmodule

@@ sv/mrfifo_ram.sv @@
// mrfifo_ram: generic single-port-write, single-port-read RAM, registered read.
// No dependencies; used for the message ring storage.
`timescale 1ns / 1ps

module mrfifo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ tb/mrfifo_result_checker.sv @@
// mrfifo_result_checker: watches the request, reply and APB ports of the message
// ring FIFO, predicts every reply from its own copy of the queue and compares it.
// Depends on mrfifo_pkg.
`timescale 1ns / 1ps

module mrfifo_result_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              o_stall,
    input  mrfifo_pkg::t_mode                 i_mode,
    input  logic [mrfifo_pkg::XDATA_W-1:0]    i_send_data,
    input  logic                              o_valid,
    input  logic                              i_stall,
    input  mrfifo_pkg::t_status               o_status,
    input  logic [mrfifo_pkg::XDATA_W-1:0]    o_recv_data,
    input  logic [mrfifo_pkg::LOSTOUT_W-1:0]  o_lost_count,
    input  logic [mrfifo_pkg::PEND_W-1:0]     o_pending_count,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mrfifo_pkg::PADDR_W-1:0]    paddr,
    input  logic [mrfifo_pkg::APB_W-1:0]      pwdata,
    input  logic [mrfifo_pkg::APB_W-1:0]      prdata,
    input  logic                              pready,
    output int                                replies_due,
    output int                                mismatch_count
);
    import mrfifo_pkg::*;

    localparam int RING_SLOTS = 16;
    localparam int LOST_LIMIT = (1 << LOSTOUT_W) - 1;
    localparam logic [PADDR_W-1:0] QDEPTH_ADDR = PADDR_W'(4 * int'(REG_QDEPTH));

    typedef struct packed {
        t_status              status;
        logic [XDATA_W-1:0]   data;
        logic [LOSTOUT_W-1:0] lost;
        logic [PEND_W-1:0]    pend;
    } fifo_reply_t;

    logic [XDATA_W-1:0]  ring [RING_SLOTS];
    int                  rd_slot;
    int                  wr_slot;
    int                  fill;
    int                  lost;
    logic [QDEPTH_W-1:0] qdepth;
    fifo_reply_t         replies_q[$];

    function automatic int slots_in_use();
        return (int'(qdepth) > RING_SLOTS) ? RING_SLOTS : int'(qdepth);
    endfunction

    function automatic int next_slot(input int idx);
        int nx;
        nx = idx + 1;
        if (nx >= slots_in_use() || nx >= RING_SLOTS) begin
            nx = 0;
        end
        return nx;
    endfunction

    // applies one operation to the shadow queue and returns its reply
    function automatic fifo_reply_t fifo_reply_for(input t_mode m, input logic [XDATA_W-1:0] d);
        fifo_reply_t r;
        r = '0;
        r.status = ST_OK;
        case (m)
            MODE_SEND: begin
                if (fill >= slots_in_use()) begin
                    if (lost < LOST_LIMIT) begin
                        lost++;
                    end
                    r.status = ST_FULL;
                end else begin
                    fill++;
                    wr_slot = next_slot(wr_slot);
                    ring[wr_slot] = d;
                end
            end
            MODE_RECV: begin
                if (fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    fill--;
                    rd_slot = next_slot(rd_slot);
                    r.data = ring[rd_slot];
                    r.lost = LOSTOUT_W'(lost);
                    lost = 0;
                end
            end
            MODE_CLEAR: begin
                r.pend = PEND_W'(fill);
                if (fill > 0) begin
                    lost = 0;
                    fill = 0;
                    rd_slot = RING_SLOTS - 1;
                    wr_slot = RING_SLOTS - 1;
                end
            end
            default: ;
        endcase
        if (m != MODE_CLEAR) begin
            r.pend = PEND_W'(fill);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [XDATA_W-1:0] want,
                                   input logic [XDATA_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 200) begin
            $display("%0t ns: %s mismatch, expected %0h got %0h", $realtime, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        fifo_reply_t want;
        if (!i_rst_n) begin
            replies_q.delete();
            foreach (ring[k]) ring[k] = '0;
            rd_slot = RING_SLOTS - 1;
            wr_slot = RING_SLOTS - 1;
            fill = 0;
            lost = 0;
            qdepth = QDEPTH_W'(QDEPTH_RST);
        end else begin
            if (psel && penable && pready && paddr == QDEPTH_ADDR) begin
                if (pwrite) begin
                    qdepth = pwdata[QDEPTH_W-1:0];
                end else if (prdata[QDEPTH_W-1:0] !== qdepth) begin
                    report_mismatch("queue_depth readback", XDATA_W'(qdepth), prdata);
                end
            end
            if (i_valid && !o_stall) begin
                replies_q.push_back(fifo_reply_for(i_mode, i_send_data));
            end
            if (o_valid && !i_stall) begin
                if (replies_q.size() == 0) begin
                    report_mismatch("unexpected transaction", '0, o_recv_data);
                end else begin
                    want = replies_q.pop_front();
                    if (o_status !== want.status)
                        report_mismatch("status", XDATA_W'(want.status), XDATA_W'(o_status));
                    if (o_recv_data !== want.data)
                        report_mismatch("recv_data", want.data, o_recv_data);
                    if (o_lost_count !== want.lost)
                        report_mismatch("lost_count", XDATA_W'(want.lost), XDATA_W'(o_lost_count));
                    if (o_pending_count !== want.pend)
                        report_mismatch("pending_count", XDATA_W'(want.pend),
                                        XDATA_W'(o_pending_count));
                end
            end
        end
        replies_due <= replies_q.size();
    end

endmodule

@@ tb/tb_message_ring_fifo_with_loss_count.sv @@
// tb_message_ring_fifo_with_loss_count: drives directed and random operations,
// queue_depth writes and random stalls into the message ring FIFO; verdict from
// mrfifo_result_checker. Depends on mrfifo_pkg and the block under test.
`timescale 1ns / 1ps

module tb_message_ring_fifo_with_loss_count;
    import mrfifo_pkg::*;

    localparam int RUN_LIMIT    = 600000;
    localparam int RANDOM_ITEMS = 1400;
    localparam int LOST_SENDS   = 40;
    localparam logic [PADDR_W-1:0] QDEPTH_ADDR = PADDR_W'(4 * int'(REG_QDEPTH));

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    t_mode                i_mode = MODE_QUERY;
    logic [XDATA_W-1:0]   i_send_data = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    t_status              o_status;
    logic [XDATA_W-1:0]   o_recv_data;
    logic [LOSTOUT_W-1:0] o_lost_count;
    logic [PEND_W-1:0]    o_pending_count;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [APB_W-1:0]     pwdata = '0;
    logic [APB_W-1:0]     prdata;
    logic                 pready;

    int replies_due;
    int mismatch_count;
    bit idling_en = 1'b1;
    int stall_left = 0;
    int cycle_count = 0;

    message_ring_fifo_with_loss_count dut (.*);

    mrfifo_result_checker u_checker (.*);

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver stall bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            if (stall_left == 1) begin
                i_stall <= 1'b0;
            end
        end else if (idling_en && $urandom_range(0, 7) == 0) begin
            i_stall <= 1'b1;
            stall_left <= $urandom_range(1, 18);
        end
    end

    task automatic push_op(input t_mode m, input logic [XDATA_W-1:0] d);
        if (idling_en && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= m;
        i_send_data <= d;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (replies_due != 0);
    endtask

    // write queue_depth, then read it back
    task automatic set_depth(input logic [QDEPTH_W-1:0] depth);
        logic [APB_W-1:0] word;
        word = $urandom();
        word[QDEPTH_W-1:0] = depth;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= QDEPTH_ADDR;
        pwdata <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        int random_done;
        int phase_no;
        int phase_len;
        int send_w;
        int recv_w;
        int pick;
        t_mode m;
        logic [XDATA_W-1:0] d;
        logic [QDEPTH_W-1:0] depth_sel;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty queue, fill every slot, overflow, receive with loss count, clears
        push_op(MODE_QUERY, $urandom());
        push_op(MODE_RECV, $urandom());
        for (int i = 0; i < 16; i++) begin
            case (i)
                0: d = '0;
                1: d = '1;
                2: d = 32'h5555_5555;
                3: d = 32'hAAAA_AAAA;
                default: d = $urandom();
            endcase
            push_op(MODE_SEND, d);
        end
        push_op(MODE_SEND, 32'h0123_4567);
        push_op(MODE_SEND, 32'hFEDC_BA98);
        push_op(MODE_RECV, $urandom());
        push_op(MODE_QUERY, $urandom());
        push_op(MODE_CLEAR, $urandom());
        push_op(MODE_RECV, $urandom());
        push_op(MODE_CLEAR, $urandom());

        random_done = 0;
        phase_no = 0;
        while (random_done < RANDOM_ITEMS) begin
            drain();
            case (phase_no)
                0: depth_sel = 1;
                1: depth_sel = 31;
                2: depth_sel = 0;
                3: depth_sel = 16;
                default: begin
                    case ($urandom_range(0, 9))
                        0: depth_sel = 0;
                        1: depth_sel = 1;
                        2: depth_sel = 16;
                        3: depth_sel = 31;
                        4, 5: depth_sel = $urandom_range(2, 4);
                        6, 7: depth_sel = $urandom_range(1, 16);
                        8: depth_sel = $urandom_range(17, 30);
                        default: depth_sel = $urandom_range(5, 8);
                    endcase
                end
            endcase
            idling_en <= ($urandom_range(0, 3) != 0);
            set_depth(depth_sel);
            case ($urandom_range(0, 2))
                0: begin send_w = 60; recv_w = 25; end
                1: begin send_w = 25; recv_w = 60; end
                default: begin send_w = 43; recv_w = 43; end
            endcase
            phase_len = $urandom_range(60, 160);
            for (int k = 0; k < phase_len; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < send_w) begin
                    m = MODE_SEND;
                end else if (pick < send_w + recv_w) begin
                    m = MODE_RECV;
                end else if (pick < send_w + recv_w + 4) begin
                    m = MODE_CLEAR;
                end else begin
                    m = MODE_QUERY;
                end
                case ($urandom_range(0, 15))
                    0: d = '0;
                    1: d = '1;
                    default: d = $urandom();
                endcase
                if ($urandom_range(0, 99) == 0) begin
                    drain();
                end
                push_op(m, d);
                random_done++;
            end
            phase_no++;
        end

        // last part, no idling: zero depth, every send is lost; then depth one
        idling_en <= 1'b0;
        drain();
        push_op(MODE_CLEAR, $urandom());
        drain();
        set_depth(0);
        repeat (LOST_SENDS) push_op(MODE_SEND, $urandom());
        push_op(MODE_CLEAR, $urandom());
        drain();
        set_depth(1);
        push_op(MODE_SEND, $urandom());
        push_op(MODE_SEND, $urandom());
        push_op(MODE_RECV, $urandom());
        push_op(MODE_QUERY, $urandom());
        drain();
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
